// ----- hw/rtl/s2cal_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// s2cal_pkg
// Constants and small helper functions for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package s2cal_pkg;

  typedef logic [31:0] secs_t;

  localparam secs_t SECS_PER_DAY  = 32'd86400;
  localparam secs_t SECS_PER_HOUR = 32'd3600;
  localparam secs_t SECS_PER_MIN  = 32'd60;

  localparam secs_t SECS_365 = 32'd31536000;
  localparam secs_t SECS_366 = 32'd31622400;

  // 2000-01-01 fell on a Saturday.
  localparam logic [2:0] WDAY_EPOCH = 3'd6;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Leap rule for years 2000 to 2255. The only century years in that span are
  // 2000, which is divisible by 400, and 2100 and 2200, which are not.
  function automatic logic is_leap(input logic [7:0] yoff);
    logic four;
    begin
      four = (yoff[1:0] == 2'b00);
      is_leap = four && (yoff != 8'd100) && (yoff != 8'd200);
    end
  endfunction

  // Length of a month in days.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    begin
      unique case (month)
        4'd2:                     month_days = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:  month_days = 5'd30;
        default:                  month_days = 5'd31;
      endcase
    end
  endfunction

  // Length of a month in seconds.
  function automatic secs_t month_secs(input logic [4:0] days);
    begin
      unique case (days)
        5'd28:   month_secs = 32'd2419200;
        5'd29:   month_secs = 32'd2505600;
        5'd30:   month_secs = 32'd2592000;
        default: month_secs = 32'd2678400;
      endcase
    end
  endfunction

  // Weekday advanced by a small count of days, modulo seven.
  function automatic logic [2:0] wday_add(input logic [2:0] wday, input logic [4:0] days);
    logic [5:0] s;
    begin
      s = {3'b000, wday} + {1'b0, days};
      for (int i = 0; i < 5; i++) begin
        if (s >= 6'd7) begin
          s = s - 6'd7;
        end
      end
      wday_add = s[2:0];
    end
  endfunction

endpackage : s2cal_pkg
`default_nettype wire

// ----- hw/rtl/seconds_to_calendar_datetime.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_datetime
// Converts a count of seconds since 2000-01-01 00:00:00 into calendar fields.
// ----------------------------------------------------------------------------
// The block takes one 32-bit count of seconds since the start of the year 2000
// and returns the Gregorian year offset, month, day, hour, minute, second and
// weekday (0 is Sunday). All work is done by a single 32-bit compare-and-
// subtract unit under a small sequencer. Whole years are removed first, one
// per cycle, then whole months, one per cycle; the day of month, hour and
// minute are then found by binary long division against shifted copies of the
// day, hour and minute lengths, one quotient bit per cycle, and what is left
// is the second. The weekday is carried along as days are removed, starting
// from the Saturday on which the epoch fell. The time from input transfer to
// result is set chiefly by the number of whole years in the input, up to 136.
// The input is stalled while a conversion is in progress; a finished result
// sits in an output register, so a new input can be taken while the previous
// result still awaits transfer.
// ----------------------------------------------------------------------------
module seconds_to_calendar_datetime
  import s2cal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [31:0] in_seconds_since_2000,

  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_year_offset,
  output      logic [3:0]  out_month,
  output      logic [4:0]  out_day,
  output      logic [4:0]  out_hour,
  output      logic [5:0]  out_minute,
  output      logic [5:0]  out_second,
  output      logic [2:0]  out_weekday
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_DAY   = 3'd3;
  localparam logic [2:0] S_HOUR  = 3'd4;
  localparam logic [2:0] S_MIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // Highest quotient bit for each division phase.
  localparam logic [2:0] DAY_TOP_BIT  = 3'd4;
  localparam logic [2:0] HOUR_TOP_BIT = 3'd4;
  localparam logic [2:0] MIN_TOP_BIT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  secs_t       rem_r, rem_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  dayq_r, dayq_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_min_r;
  logic [5:0]  out_sec_r;
  logic [2:0]  out_wday_r;

  logic        leap;
  logic [4:0]  mdays;
  secs_t       sub_val;
  logic        ge;
  secs_t       diff;
  logic        in_xfer;
  logic        out_free;
  logic        load_out;

  assign leap  = is_leap(year_r);
  assign mdays = month_days(month_r, leap);

  // The shared unit: one subtrahend chosen per phase, one compare, one subtract.
  always_comb begin
    unique case (state_r)
      S_YEAR:  sub_val = leap ? SECS_366 : SECS_365;
      S_MONTH: sub_val = month_secs(mdays);
      S_DAY:   sub_val = SECS_PER_DAY << step_r;
      S_HOUR:  sub_val = SECS_PER_HOUR << step_r;
      S_MIN:   sub_val = SECS_PER_MIN << step_r;
      default: sub_val = '0;
    endcase
  end

  assign ge   = (rem_r >= sub_val);
  assign diff = rem_r - sub_val;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    dayq_nxt      = dayq_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    wday_nxt      = wday_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rem_nxt   = in_seconds_since_2000;
          year_nxt  = '0;
          month_nxt = MONTH_JAN;
          dayq_nxt  = '0;
          hour_nxt  = '0;
          min_nxt   = '0;
          wday_nxt  = WDAY_EPOCH;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (ge) begin
          rem_nxt  = diff;
          year_nxt = year_r + 8'd1;
          // A year moves the weekday on by one day, a leap year by two.
          wday_nxt = wday_add(wday_r, leap ? 5'd2 : 5'd1);
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (ge && (month_r < MONTH_DEC)) begin
          rem_nxt   = diff;
          month_nxt = month_r + 4'd1;
          wday_nxt  = wday_add(wday_r, mdays - 5'd28);
        end else begin
          step_nxt  = DAY_TOP_BIT;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        if (ge) begin
          rem_nxt          = diff;
          dayq_nxt[step_r] = 1'b1;
        end
        if (step_r == '0) begin
          step_nxt  = HOUR_TOP_BIT;
          state_nxt = S_HOUR;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      S_HOUR: begin
        if (ge) begin
          rem_nxt          = diff;
          hour_nxt[step_r] = 1'b1;
        end
        if (step_r == '0) begin
          step_nxt  = MIN_TOP_BIT;
          state_nxt = S_MIN;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      S_MIN: begin
        if (ge) begin
          rem_nxt         = diff;
          min_nxt[step_r] = 1'b1;
        end
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    rem_r   <= rem_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    dayq_r  <= dayq_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    wday_r  <= wday_nxt;
  end

  // Result register; the remainder left after the minute phase is the second.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_year_r  <= year_r;
      out_month_r <= month_r;
      out_day_r   <= dayq_r + 5'd1;
      out_hour_r  <= hour_r;
      out_min_r   <= min_r;
      out_sec_r   <= rem_r[5:0];
      out_wday_r  <= wday_add(wday_r, dayq_r);
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_year_offset = out_year_r;
  assign out_month       = out_month_r;
  assign out_day         = out_day_r;
  assign out_hour        = out_hour_r;
  assign out_minute      = out_min_r;
  assign out_second      = out_sec_r;
  assign out_weekday     = out_wday_r;

endmodule : seconds_to_calendar_datetime
`default_nettype wire
